FILE: hdl/psl_pkg.sv
// ----------------------------------------------------------------------------
// psl_pkg: shared types and constants of the path selector
// Field widths, mode codes and the latency compare node used by the core.
// ----------------------------------------------------------------------------
package psl_pkg;

  // Fixed field widths.
  localparam int NUM_PATHS  = 8;
  localparam int TGT_W      = 4;
  localparam int MASK_W     = 8;
  localparam int LAT_W      = 32;
  localparam int PATH_W     = 3;
  localparam int POS_W      = 3;
  localparam int CNT_W      = 4;
  localparam int MODE_W     = 2;
  localparam int IN_DATA_W  = 280;
  localparam int OUT_DATA_W = 8;

  // Latencies at or above this limit count as unmeasured.
  localparam logic [LAT_W-1:0] LATENCY_LIMIT = 32'd1000000000;

  // Selection modes; any other code acts as first eligible.
  localparam logic [MODE_W-1:0] MODE_LATENCY = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FIRST   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RR      = 2'd2;

  // One candidate of the lowest-latency search.
  typedef struct packed {
    logic              vld;
    logic [LAT_W-1:0]  lat;
    logic [PATH_W-1:0] idx;
  } lat_node_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_CALC = 2'b10
  } state_t;

  // Picks the better of two candidates; a holds the lower path index, so
  // it wins ties.
  function automatic lat_node_t node_min(lat_node_t a, lat_node_t b);
    lat_node_t r;
    if (a.vld && (!b.vld || (a.lat <= b.lat))) begin
      r = a;
    end else begin
      r = b;
    end
    return r;
  endfunction

endpackage

FILE: hdl/path_selector_latency_rr_core.sv
// ----------------------------------------------------------------------------
// path_selector_latency_rr_core: per-request network path selector
// Picks one path out of the eligible set by lowest latency, first index or
// per-target round robin, with round-robin positions held in a small RAM.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake              Contents
//  in_      slave      in_tvalid / in_tready   target, masks, eight latencies
//  out_     master     out_tvalid / out_tready path_found, chosen_path
//  cfg_     slave      cfg_valid / cfg_ready   select_mode
//
// An item is taken in S_IDLE, where the accept cycle reads the position
// RAM and runs the first level of the latency compare tree, and then
// S_CALC finishes the tree, picks the path and writes the position back.
// The output register lets a new item be accepted while a result waits;
// a held result stalls S_CALC. Reset clears the mode to first
// eligible and the position valid bits, so every position reads as zero.
module path_selector_latency_rr_core
  import psl_pkg::*;
#(
  parameter int NUM_TARGETS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Fields from bit 0: target_index[3:0], offered_mask[11:4],
  // reachable_mask[19:12], latency_p0..latency_p7 32 bits each from bit 20.
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // Fields from bit 0: path_found[0], chosen_path[3:1], zero fill.
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [MODE_W-1:0]     cfg_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready
);

  localparam int TW = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;
  localparam int HALF = NUM_PATHS / 2;

  state_t            state_r, state_nxt;
  logic [MODE_W-1:0] mode_r;
  logic [TW-1:0]     tgt_r;
  logic [MASK_W-1:0] elig_r;
  lat_node_t         lvl1_r [HALF];
  logic [POS_W-1:0]  pos_rd_r;
  logic              out_tvalid_r;
  logic              found_r;
  logic [PATH_W-1:0] chosen_r;

  // Position store with one valid bit per entry.
  logic [POS_W-1:0]       pos_mem [NUM_TARGETS];
  logic [NUM_TARGETS-1:0] pos_vld_r;

  logic              in_fire;
  logic              calc_go;
  logic [TW-1:0]     in_tgt;
  logic [MASK_W-1:0] in_elig;
  lat_node_t         in_node [NUM_PATHS];
  lat_node_t         l2_node [2];
  lat_node_t         best_node;
  logic [TW-1:0]     tgt_lut [16];
  logic [POS_W-1:0]  mod_lut [8][8];
  logic [CNT_W-1:0]  elig_cnt;
  logic [CNT_W-1:0]  cnt_m1;
  logic [POS_W-1:0]  rr_pos;
  logic [POS_W-1:0]  rr_pos_nxt;
  logic [PATH_W-1:0] first_idx;
  logic [PATH_W-1:0] rr_pick;
  logic [PATH_W-1:0] pick;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign calc_go   = (state_r == S_CALC) && (!out_tvalid_r || out_tready);

  // Constant tables: target index folded into the store depth, and the
  // stored position reduced by the eligible count.
  for (genvar k = 0; k < 16; k++) begin : g_tgt_lut
    localparam int TGT_FOLD = k % NUM_TARGETS;
    assign tgt_lut[k] = TW'(TGT_FOLD);
  end
  for (genvar a = 0; a < 8; a++) begin : g_mod_a
    for (genvar c = 0; c < 8; c++) begin : g_mod_c
      localparam int POS_MOD = a % (c + 1);
      assign mod_lut[a][c] = POS_W'(POS_MOD);
    end
  end

  // Input decode: eligible set and usable latencies.
  assign in_tgt  = tgt_lut[in_tdata[TGT_W-1:0]];
  assign in_elig = in_tdata[TGT_W +: MASK_W] & in_tdata[TGT_W+MASK_W +: MASK_W];

  always_comb begin
    logic [LAT_W-1:0] lat;
    for (int i = 0; i < NUM_PATHS; i++) begin
      lat = in_tdata[TGT_W + 2*MASK_W + i*LAT_W +: LAT_W];
      in_node[i].vld = in_elig[i] && (lat != '0) && (lat < LATENCY_LIMIT);
      in_node[i].lat = lat;
      in_node[i].idx = PATH_W'(i);
    end
  end

  // Capture the item, run the first compare level and read the position.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      tgt_r    <= in_tgt;
      elig_r   <= in_elig;
      pos_rd_r <= pos_vld_r[in_tgt] ? pos_mem[in_tgt] : '0;
      for (int j = 0; j < HALF; j++) begin
        lvl1_r[j] <= node_min(in_node[2*j], in_node[2*j+1]);
      end
    end
  end

  // Remaining compare levels of the latency search.
  assign l2_node[0] = node_min(lvl1_r[0], lvl1_r[1]);
  assign l2_node[1] = node_min(lvl1_r[2], lvl1_r[3]);
  assign best_node  = node_min(l2_node[0], l2_node[1]);

  // Lowest eligible index.
  always_comb begin
    first_idx = '0;
    for (int i = NUM_PATHS - 1; i >= 0; i--) begin
      if (elig_r[i]) begin
        first_idx = PATH_W'(i);
      end
    end
  end

  // Round robin: reduce the stored position and find that eligible path.
  assign elig_cnt   = CNT_W'($countones(elig_r));
  assign cnt_m1     = elig_cnt - CNT_W'(1);
  assign rr_pos     = mod_lut[pos_rd_r][cnt_m1[POS_W-1:0]];
  assign rr_pos_nxt = (CNT_W'(rr_pos) + CNT_W'(1) == elig_cnt) ? '0 : rr_pos + POS_W'(1);

  always_comb begin
    logic [CNT_W-1:0] seen;
    logic             hit;
    seen    = '0;
    hit     = 1'b0;
    rr_pick = '0;
    for (int i = 0; i < NUM_PATHS; i++) begin
      if (elig_r[i]) begin
        if (!hit && (seen == CNT_W'(rr_pos))) begin
          rr_pick = PATH_W'(i);
          hit     = 1'b1;
        end
        seen = seen + CNT_W'(1);
      end
    end
  end

  // Mode selection.
  always_comb begin
    case (mode_r)
      MODE_LATENCY: pick = best_node.vld ? best_node.idx : first_idx;
      MODE_RR:      pick = rr_pick;
      default:      pick = first_idx;
    endcase
  end

  // Position write-back, round-robin mode with a nonempty set only.
  always_ff @(posedge clk) begin
    if (calc_go && (mode_r == MODE_RR) && (elig_r != '0)) begin
      pos_mem[tgt_r] <= rr_pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_vld_r <= '0;
    end else if (calc_go && (mode_r == MODE_RR) && (elig_r != '0)) begin
      pos_vld_r[tgt_r] <= 1'b1;
    end
  end

  // Controller.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_CALC;
      S_CALC:  if (calc_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= MODE_FIRST;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_data;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (calc_go) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (calc_go) begin
      found_r  <= (elig_r != '0);
      chosen_r <= (elig_r != '0) ? pick : '0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {(OUT_DATA_W - PATH_W - 1)'(0), chosen_r, found_r};

endmodule

FILE: tb/sv/path_select_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// path_select_checker: result predictor and comparator for the path selector
// Watches the request, result and mode channels of the core. Every accepted
// request is run through a cycle-free model of the selection rules with its
// own mode register and round-robin position store, and the expected pick is
// queued. Every accepted result is compared field by field with the oldest
// queued pick, and mismatches are counted for the testbench top.
// ----------------------------------------------------------------------------
module path_select_checker
  import psl_pkg::*;
#(
  parameter int NUM_TARGETS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [MODE_W-1:0]     cfg_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  output int                    pending_picks,
  output int                    error_count
);

  localparam int LAT_BASE = TGT_W + 2 * MASK_W;

  typedef struct packed {
    logic              found;
    logic [PATH_W-1:0] path;
  } pick_t;

  pick_t             expected_picks[$];
  logic [MODE_W-1:0] mode_model;
  logic [POS_W-1:0]  rr_pos_model [NUM_TARGETS];
  int                errors = 0;

  assign error_count = errors;

  // One line per mismatch, and one more on the failure count.
  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    errors++;
  endtask

  // Works out the pick for one request and advances the round-robin store.
  function automatic pick_t predict_pick(input logic [IN_DATA_W-1:0] d);
    logic [MASK_W-1:0] elig;
    logic [LAT_W-1:0]  lat;
    logic [LAT_W-1:0]  best;
    logic              have;
    int                first;
    int                cnt;
    int                pos;
    int                seen;
    int                tgt;
    pick_t             p;
    elig = d[TGT_W +: MASK_W] & d[TGT_W + MASK_W +: MASK_W];
    p = '0;
    if (elig == '0) begin
      return p;
    end
    p.found = 1'b1;
    first = 0;
    for (int i = NUM_PATHS - 1; i >= 0; i--) begin
      if (elig[i]) first = i;
    end
    case (mode_model)
      MODE_LATENCY: begin
        // Smallest usable latency, lowest index on ties, else first eligible.
        have = 1'b0;
        best = '0;
        p.path = PATH_W'(first);
        for (int i = 0; i < NUM_PATHS; i++) begin
          lat = d[LAT_BASE + i * LAT_W +: LAT_W];
          if (elig[i] && lat != '0 && lat < LATENCY_LIMIT && (!have || lat < best)) begin
            have = 1'b1;
            best = lat;
            p.path = PATH_W'(i);
          end
        end
      end
      MODE_RR: begin
        // A stale position is folded into the current eligible count.
        tgt = int'(d[TGT_W-1:0]) % NUM_TARGETS;
        cnt = $countones(elig);
        pos = int'(rr_pos_model[tgt]) % cnt;
        seen = 0;
        for (int i = 0; i < NUM_PATHS; i++) begin
          if (elig[i]) begin
            if (seen == pos) p.path = PATH_W'(i);
            seen++;
          end
        end
        rr_pos_model[tgt] = POS_W'((pos + 1) % cnt);
      end
      default: begin
        p.path = PATH_W'(first);
      end
    endcase
    return p;
  endfunction

  // Channel monitor: mode writes, result compare, then request prediction.
  always @(posedge clk) begin : watch
    pick_t got;
    pick_t want;
    if (!rst_n) begin
      mode_model = MODE_FIRST;
      for (int t = 0; t < NUM_TARGETS; t++) rr_pos_model[t] = '0;
      expected_picks.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_model = cfg_data;
      end
      if (out_tvalid && out_tready) begin
        got.found = out_tdata[0];
        got.path  = out_tdata[PATH_W:1];
        if (expected_picks.size() == 0) begin
          report_mismatch($sformatf("result found=%0b path=%0d with no request pending",
                                    got.found, got.path));
        end else begin
          want = expected_picks.pop_front();
          if (got.found !== want.found) begin
            report_mismatch($sformatf("path_found %0b, expected %0b",
                                      got.found, want.found));
          end
          if (got.path !== want.path) begin
            report_mismatch($sformatf("chosen_path %0d, expected %0d",
                                      got.path, want.path));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        expected_picks.insert(expected_picks.size(), predict_pick(in_tdata));
      end
    end
    pending_picks <= expected_picks.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the path selector core
// Drives a directed set of requests through every selection mode and its
// corner cases, then several phases of random requests, each under a set
// mode, with random gaps and stalls on both channels and one long output
// stall. Checking is done by the path_select_checker beside the core.
// ----------------------------------------------------------------------------
module tb_top;
  import psl_pkg::*;

  localparam int NUM_TARGETS = 16;
  localparam int LAT_BASE    = TGT_W + 2 * MASK_W;
  localparam int LATS_W      = NUM_PATHS * LAT_W;
  localparam int PHASE_ITEMS = 100;
  localparam int NUM_PHASES  = 6;
  // Undefined code; the core treats it as first eligible.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [MODE_W-1:0]     cfg_data   = '0;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  int                    pending_picks;
  int                    error_count;
  int                    results_taken = 0;
  bit                    sender_bursty = 1'b0;
  logic [MASK_W-1:0]     reach_table [4];

  path_selector_latency_rr_core #(
    .NUM_TARGETS (NUM_TARGETS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_data   (cfg_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
  );

  path_select_checker #(
    .NUM_TARGETS (NUM_TARGETS)
  ) u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tdata      (in_tdata),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .out_tdata     (out_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .cfg_data      (cfg_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .pending_picks (pending_picks),
    .error_count   (error_count)
  );

  // 100 MHz clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  // Offers one request after a random gap and waits for its handshake.
  task automatic send_request(input logic [TGT_W-1:0] tgt, input logic [MASK_W-1:0] offered,
                              input logic [MASK_W-1:0] reachable,
                              input logic [LATS_W-1:0] lats);
    logic [IN_DATA_W-1:0] data;
    int                   gap;
    gap = sender_bursty ? 0 : $urandom_range(0, 15);
    data = '0;
    data[TGT_W-1:0] = tgt;
    data[TGT_W +: MASK_W] = offered;
    data[TGT_W + MASK_W +: MASK_W] = reachable;
    data[LAT_BASE +: LATS_W] = lats;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= data;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  // Mode writes happen only once every pending result has come out.
  task automatic write_mode(input logic [MODE_W-1:0] mode);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_picks != 0) @(posedge clk);
    cfg_data  <= mode;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mix of missing, huge, tiny (tie-prone), just-below-limit and fully random latencies.
  function automatic logic [LAT_W-1:0] random_latency();
    logic [LAT_W-1:0] v;
    case ($urandom_range(0, 7))
      0:       v = '0;
      1:       v = $urandom_range(LATENCY_LIMIT, 32'hFFFF_FFFF);
      2, 3:    v = $urandom_range(1, 8);
      4:       v = LATENCY_LIMIT - 1;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // Random request; most go to a few targets with a stable reachable set so
  // that round-robin positions really rotate.
  task automatic random_request();
    logic [TGT_W-1:0]  tgt;
    logic [MASK_W-1:0] offered;
    logic [MASK_W-1:0] reachable;
    logic [LATS_W-1:0] lats;
    int                sel;
    if ($urandom_range(0, 3) != 0) begin
      tgt = TGT_W'($urandom_range(0, 3));
      reachable = ($urandom_range(0, 4) != 0) ? reach_table[tgt[1:0]] : MASK_W'($urandom());
    end else begin
      tgt = TGT_W'($urandom_range(0, 15));
      reachable = MASK_W'($urandom());
    end
    sel = $urandom_range(0, 9);
    if (sel < 5) begin
      offered = '1;
    end else if (sel < 8) begin
      offered = MASK_W'($urandom());
    end else begin
      offered = (MASK_W'(1) << $urandom_range(0, 7)) | (MASK_W'(1) << $urandom_range(0, 7));
    end
    for (int i = 0; i < NUM_PATHS; i++) lats[i * LAT_W +: LAT_W] = random_latency();
    send_request(tgt, offered, reachable, lats);
  endtask

  // Result sink: a random wait per item, bursts with no wait, and one long
  // hold-off so the core backs up and stalls its input.
  initial begin : sink
    int hold;
    bit burst;
    burst = 1'b0;
    forever begin
      if (results_taken == 150) begin
        hold = 400;
      end else begin
        hold = burst ? 0 : $urandom_range(0, 15);
      end
      if ($urandom_range(0, 29) == 0) burst = !burst;
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      results_taken++;
    end
  end

  // Reset, directed requests, random phases and the verdict.
  initial begin : stimulus
    logic [LATS_W-1:0] lats;
    logic [MODE_W-1:0] phase_modes [NUM_PHASES];
    phase_modes = '{MODE_RR, MODE_LATENCY, MODE_FIRST, MODE_RR, MODE_UNUSED, MODE_LATENCY};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Mode after reset is first eligible: empty set, all paths, top path only.
    send_request(4'd0, 8'hFF, 8'h00, {NUM_PATHS{32'hFFFF_FFFF}});
    send_request(4'd15, 8'hFF, 8'hFF, '0);
    send_request(4'd5, 8'h80, 8'h80, {NUM_PATHS{32'hFFFF_FFFF}});

    // Lowest latency mode.
    write_mode(MODE_LATENCY);
    // No measurements at all falls back to the first eligible path.
    send_request(4'd1, 8'h0C, 8'hFF, '0);
    // Only huge values also fall back.
    send_request(4'd2, 8'hFF, 8'hF0, {NUM_PATHS{32'hFFFF_FFFF}});
    // A value at the limit is unusable, one just below it is usable.
    lats = '0;
    lats[3 * LAT_W +: LAT_W] = LATENCY_LIMIT;
    lats[5 * LAT_W +: LAT_W] = LATENCY_LIMIT - 1;
    send_request(4'd3, 8'hFF, 8'hFF, lats);
    // Tie goes to the lower index.
    lats = '0;
    lats[1 * LAT_W +: LAT_W] = 32'd9;
    lats[2 * LAT_W +: LAT_W] = 32'd7;
    lats[6 * LAT_W +: LAT_W] = 32'd7;
    send_request(4'd4, 8'hFF, 8'hFF, lats);
    // A lower latency on an ineligible path is ignored.
    lats = '0;
    lats[0 * LAT_W +: LAT_W] = 32'd1;
    lats[4 * LAT_W +: LAT_W] = 32'd100;
    lats[7 * LAT_W +: LAT_W] = 32'd2;
    send_request(4'd6, 8'hFE, 8'hFF, lats);
    lats = {NUM_PATHS{LATENCY_LIMIT - 1}};
    lats[6 * LAT_W +: LAT_W] = 32'd1;
    send_request(4'd7, 8'hFF, 8'hFF, lats);
    send_request(4'd8, 8'h0F, 8'hF0, lats);

    // Round robin: rotation, wrap, a stale position, an empty set, top target.
    write_mode(MODE_RR);
    repeat (4) send_request(4'd3, 8'h2A, 8'hFF, '0);
    send_request(4'd3, 8'hFF, 8'h11, '0);
    send_request(4'd3, 8'h00, 8'hFF, '0);
    send_request(4'd3, 8'hFF, 8'h11, '0);
    repeat (3) send_request(4'd15, 8'hFF, 8'hFF, {NUM_PATHS{32'hFFFF_FFFF}});

    // Undefined mode code acts as first eligible.
    write_mode(MODE_UNUSED);
    send_request(4'd9, 8'hE0, 8'h7F, '0);
    send_request(4'd10, 8'hFF, 8'hFF, '0);

    // Random phases, each under its own mode and reachable sets.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_mode(phase_modes[ph]);
      for (int t = 0; t < 4; t++) reach_table[t] = MASK_W'($urandom_range(1, 255));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 19) == 0) sender_bursty = !sender_bursty;
        random_request();
      end
    end
    write_mode(MODE_FIRST);
    repeat (20) random_request();

    // Drain and decide.
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_picks != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/psl_pkg.sv
hdl/path_selector_latency_rr_core.sv
tb/sv/path_select_checker.sv
tb/sv/tb_top.sv
